### rtl/core/psm_pkg.sv
package psm_pkg;

   localparam int MAX_PROCS_DEF = 32;
   localparam int PNUM_W = 6;
   localparam int BURST_W = 16;
   localparam int PRIO_W = 8;
   localparam int TIME_W = 21;
   localparam int ELAPSED_W = 22;
   localparam int TOT_W = 28;
   localparam int STEP_W = 5;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef enum logic {
      ROW_PROCESS = 1'b0,
      ROW_SUMMARY = 1'b1
   } row_kind_type;

   typedef struct packed {
      logic [BURST_W-1:0] burst_time;
      logic [PRIO_W-1:0]  priority_req;
      logic               last_process;
   } req_type;

   typedef struct packed {
      logic               row_kind;
      logic [PNUM_W-1:0]  process_number;
      logic [BURST_W-1:0] burst_out;
      logic [TIME_W-1:0]  waiting_time;
      logic [TIME_W-1:0]  turnaround_time;
      logic [TIME_W-1:0]  avg_waiting;
      logic [TIME_W-1:0]  avg_turnaround;
      logic               last_result;
   } rsp_type;

   // One stored process.
   typedef struct packed {
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  prio;
      logic [PNUM_W-1:0]  num;
   } rec_type;

   typedef struct packed {
      logic wr_load;
      logic wr_sel;
      logic wr_first;
      logic take_first;
      logic take_sel;
      logic clr_emit;
      logic load_row;
      logic div_start_w;
      logic div_start_t;
      logic div_step;
      logic div_take_w;
      logic load_sum;
   } cmd_type;

   typedef struct packed {
      logic less;
      logic out_free;
   } status_type;

   function automatic logic [TIME_W-1:0] sat_time(input logic [TOT_W-1:0] v);
      logic [TIME_W-1:0] r;
      if (v > TOT_W'(TIME_MAX)) begin
         r = TIME_MAX;
      end else begin
         r = v[TIME_W-1:0];
      end
      return r;
   endfunction

endpackage

### rtl/core/psm_ram.sv
module psm_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/psm_dp.sv
module psm_dp #(
   parameter int MAX_PROCS = psm_pkg::MAX_PROCS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  psm_pkg::cmd_type        cmd,
   output psm_pkg::status_type     status,
   input  logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] wr_addr,
   input  logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] rd_addr,
   input  logic [$clog2(MAX_PROCS + 1)-1:0] div_n,
   input  psm_pkg::req_type        req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output psm_pkg::rsp_type        rsp_data
);

   localparam int RW = $bits(psm_pkg::rec_type);

   psm_pkg::rec_type rdata;
   psm_pkg::rec_type wdata;
   psm_pkg::rec_type load_rec;
   psm_pkg::rec_type first_ff;
   psm_pkg::rec_type sel_ff;
   logic we;

   logic [psm_pkg::ELAPSED_W-1:0] elapsed_ff, elapsed_in, turn;
   logic [psm_pkg::TOT_W-1:0] tot_w_ff, tot_t_ff;
   logic [psm_pkg::TOT_W-1:0] q_ff;
   logic [psm_pkg::PNUM_W-1:0] r_ff;
   logic [psm_pkg::PNUM_W:0] trial;
   logic [psm_pkg::PNUM_W:0] divisor;
   logic [psm_pkg::TIME_W-1:0] avg_w_ff;
   logic rsp_valid_ff;
   psm_pkg::rsp_type rsp_ff;

   always_comb begin
      load_rec.burst = req_data.burst_time;
      load_rec.prio = req_data.priority_req;
      load_rec.num = psm_pkg::PNUM_W'(wr_addr) + psm_pkg::PNUM_W'(1);
      priority if (cmd.wr_load) begin
         wdata = load_rec;
      end else if (cmd.wr_sel) begin
         wdata = sel_ff;
      end else begin
         wdata = first_ff;
      end
   end

   assign we = cmd.wr_load | cmd.wr_sel | cmd.wr_first;

   psm_ram #(.WIDTH(RW), .DEPTH(MAX_PROCS)) u_store (
      .clock (clock),
      .we    (we),
      .waddr (wr_addr),
      .wdata (wdata),
      .raddr (rd_addr),
      .rdata (rdata)
   );

   assign status.less = rdata.prio < sel_ff.prio;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign turn = elapsed_ff + psm_pkg::ELAPSED_W'(rdata.burst);
   assign elapsed_in = turn;
   assign divisor = {1'b0, psm_pkg::PNUM_W'(div_n)};
   assign trial = {r_ff, q_ff[psm_pkg::TOT_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.take_first) begin
         first_ff <= rdata;
         sel_ff <= rdata;
      end else if (cmd.take_sel) begin
         sel_ff <= rdata;
      end

      if (cmd.clr_emit) begin
         elapsed_ff <= '0;
         tot_w_ff <= '0;
         tot_t_ff <= '0;
      end else if (cmd.load_row) begin
         elapsed_ff <= elapsed_in;
         tot_w_ff <= tot_w_ff + psm_pkg::TOT_W'(elapsed_ff);
         tot_t_ff <= tot_t_ff + psm_pkg::TOT_W'(turn);
      end

      // Restoring division, one quotient bit per step.
      priority if (cmd.div_start_w) begin
         q_ff <= tot_w_ff;
         r_ff <= '0;
      end else if (cmd.div_start_t) begin
         q_ff <= tot_t_ff;
         r_ff <= '0;
      end else if (cmd.div_step) begin
         if (trial >= divisor) begin
            r_ff <= psm_pkg::PNUM_W'(trial - divisor);
            q_ff <= {q_ff[psm_pkg::TOT_W-2:0], 1'b1};
         end else begin
            r_ff <= trial[psm_pkg::PNUM_W-1:0];
            q_ff <= {q_ff[psm_pkg::TOT_W-2:0], 1'b0};
         end
      end

      if (cmd.div_take_w) begin
         avg_w_ff <= psm_pkg::sat_time(q_ff);
      end

      if (cmd.load_row) begin
         rsp_ff.row_kind <= psm_pkg::ROW_PROCESS;
         rsp_ff.process_number <= rdata.num;
         rsp_ff.burst_out <= rdata.burst;
         rsp_ff.waiting_time <= psm_pkg::sat_time(psm_pkg::TOT_W'(elapsed_ff));
         rsp_ff.turnaround_time <= psm_pkg::sat_time(psm_pkg::TOT_W'(turn));
         rsp_ff.avg_waiting <= '0;
         rsp_ff.avg_turnaround <= '0;
         rsp_ff.last_result <= 1'b0;
      end else if (cmd.load_sum) begin
         rsp_ff.row_kind <= psm_pkg::ROW_SUMMARY;
         rsp_ff.process_number <= '0;
         rsp_ff.burst_out <= '0;
         rsp_ff.waiting_time <= '0;
         rsp_ff.turnaround_time <= '0;
         rsp_ff.avg_waiting <= avg_w_ff;
         rsp_ff.avg_turnaround <= psm_pkg::sat_time(q_ff);
         rsp_ff.last_result <= 1'b1;
      end

      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_row || cmd.load_sum) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_row_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.row_kind == psm_pkg::ROW_PROCESS &&
       rsp_ff.turnaround_time != psm_pkg::TIME_MAX) |->
      (rsp_ff.turnaround_time ==
       rsp_ff.waiting_time + psm_pkg::TIME_W'(rsp_ff.burst_out)))
      else $error("turnaround differs from waiting plus burst");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_row || cmd.load_sum) |-> status.out_free)
      else $error("result register overwritten before transfer");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (div_n != '0))
      else $error("division by zero count");

endmodule

### rtl/core/psm_ctrl.sv
module psm_ctrl #(
   parameter int MAX_PROCS = psm_pkg::MAX_PROCS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_last,
   output psm_pkg::cmd_type        cmd,
   input  psm_pkg::status_type     status,
   output logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] wr_addr,
   output logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] rd_addr,
   output logic [$clog2(MAX_PROCS + 1)-1:0] div_n
);

   localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PROCS);
   localparam logic [psm_pkg::STEP_W-1:0] LAST_STEP = psm_pkg::STEP_W'(psm_pkg::TOT_W - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RDI, S_GETI, S_RDJ, S_CMPJ, S_WR1, S_WR2,
      S_RDK, S_OUTK, S_DSW, S_DIVW, S_DIVT, S_SUM
   } state_type;

   state_type state_ff;
   logic [CW-1:0] cnt_ff, n_ff, i_ff, j_ff, sel_ff, k_ff;
   logic [psm_pkg::STEP_W-1:0] step_ff;
   logic accept, room;
   logic [CW-1:0] n_in;
   logic take_w_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign room = cnt_ff < CNT_MAX;
   assign n_in = room ? cnt_ff + CW'(1) : cnt_ff;
   assign div_n = n_ff;

   always_comb begin
      cmd = '0;
      wr_addr = cnt_ff[AW-1:0];
      rd_addr = i_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            cmd.wr_load = accept && room;
         end
         S_RDI: rd_addr = i_ff[AW-1:0];
         S_GETI: cmd.take_first = 1'b1;
         S_RDJ: rd_addr = j_ff[AW-1:0];
         S_CMPJ: cmd.take_sel = status.less;
         S_WR1: begin
            cmd.wr_sel = 1'b1;
            wr_addr = i_ff[AW-1:0];
         end
         S_WR2: begin
            cmd.wr_first = 1'b1;
            wr_addr = sel_ff[AW-1:0];
            cmd.clr_emit = (i_ff + CW'(1)) >= n_ff;
         end
         S_RDK: rd_addr = k_ff[AW-1:0];
         S_OUTK: begin
            rd_addr = k_ff[AW-1:0];
            cmd.load_row = status.out_free;
         end
         S_DSW: cmd.div_start_w = 1'b1;
         S_DIVW: begin
            cmd.div_step = 1'b1;
         end
         S_DIVT: begin
            // The first average is taken here, then the second division starts.
            if (take_w_ff) begin
               cmd.div_take_w = 1'b1;
               cmd.div_start_t = 1'b1;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_SUM: cmd.load_sum = status.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         n_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         sel_ff <= '0;
         k_ff <= '0;
         step_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_last) begin
                     n_ff <= n_in;
                     cnt_ff <= '0;
                     i_ff <= '0;
                     state_ff <= S_RDI;
                  end else begin
                     cnt_ff <= n_in;
                  end
               end
            end
            S_RDI: state_ff <= S_GETI;
            S_GETI: begin
               sel_ff <= i_ff;
               j_ff <= i_ff + CW'(1);
               state_ff <= ((i_ff + CW'(1)) < n_ff) ? S_RDJ : S_WR1;
            end
            S_RDJ: state_ff <= S_CMPJ;
            S_CMPJ: begin
               if (status.less) begin
                  sel_ff <= j_ff;
               end
               j_ff <= j_ff + CW'(1);
               state_ff <= ((j_ff + CW'(1)) < n_ff) ? S_RDJ : S_WR1;
            end
            S_WR1: state_ff <= S_WR2;
            S_WR2: begin
               i_ff <= i_ff + CW'(1);
               k_ff <= '0;
               state_ff <= ((i_ff + CW'(1)) < n_ff) ? S_RDI : S_RDK;
            end
            S_RDK: state_ff <= S_OUTK;
            S_OUTK: begin
               if (status.out_free) begin
                  k_ff <= k_ff + CW'(1);
                  state_ff <= ((k_ff + CW'(1)) < n_ff) ? S_RDK : S_DSW;
               end
            end
            S_DSW: begin
               step_ff <= '0;
               state_ff <= S_DIVW;
            end
            S_DIVW: begin
               step_ff <= step_ff + psm_pkg::STEP_W'(1);
               if (step_ff == LAST_STEP) begin
                  step_ff <= '0;
                  state_ff <= S_DIVT;
               end
            end
            S_DIVT: begin
               if (!take_w_ff) begin
                  step_ff <= step_ff + psm_pkg::STEP_W'(1);
                  if (step_ff == LAST_STEP) begin
                     state_ff <= S_SUM;
                  end
               end
            end
            S_SUM: begin
               if (status.out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Hand-off between the two divisions happens on the first cycle of S_DIVT.
   always_ff @(posedge clock) begin
      if (reset) begin
         take_w_ff <= 1'b0;
      end else begin
         take_w_ff <= (state_ff == S_DIVW) && (step_ff == LAST_STEP);
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("loaded count above capacity");

   a_n_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (n_ff != '0 && n_ff <= CNT_MAX))
      else $error("list length out of range while busy");

   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR2) |-> (sel_ff >= i_ff && sel_ff < n_ff))
      else $error("selected index outside unsorted part");

   a_take_state: assert property (@(posedge clock) disable iff (reset)
      take_w_ff |-> (state_ff == S_DIVT))
      else $error("hand-off flag outside second division");

endmodule

### rtl/core/priority_schedule_metrics.sv
// Non-preemptive priority scheduler with timing metrics.
// Input channel (req_valid/req_ready/req_data): one transaction per process,
// carrying its burst time and priority; last_process closes the job list.
// Processes are numbered from 1 in arrival order. Once MAX_PROCS are held,
// further processes are dropped, but a closing flag still ends the list.
// Transactions are taken whenever the block is idle. After the closing
// transaction req_ready stays low while the list is ordered by ascending
// priority with a selection sort over the process store (one write and one
// read port): each pass reads and compares every candidate in turn, then
// writes the two swapped records back. The rows then leave one by one on the
// result channel (rsp_valid/rsp_ready/rsp_data), each with number, burst,
// waiting and turnaround time, followed by a summary row whose averages come
// from a restoring divider of 28 steps per average.
// The result register lets a row wait while the next one is fetched; a stalled
// receiver simply holds the block in its emit phase, nothing is lost.
// Synchronous reset empties the list and clears the result channel.
module priority_schedule_metrics #(
   parameter int MAX_PROCS = psm_pkg::MAX_PROCS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  psm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output psm_pkg::rsp_type rsp_data
);

   localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW = $clog2(MAX_PROCS + 1);

   psm_pkg::cmd_type    cmd;
   psm_pkg::status_type status;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [CW-1:0] div_n;

   psm_ctrl #(.MAX_PROCS(MAX_PROCS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_last  (req_data.last_process),
      .cmd       (cmd),
      .status    (status),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .div_n     (div_n)
   );

   psm_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .div_n     (div_n),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### tb/sv/psm_checker.sv
`timescale 1ns / 100ps
module psm_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  psm_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  psm_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               rows_pending,
   output int               lists_done
);

   localparam int MAX_PROCS = psm_pkg::MAX_PROCS_DEF;

   psm_pkg::rec_type job_list [MAX_PROCS];
   int held_count;
   psm_pkg::rsp_type row_queue [$];

   function automatic logic [psm_pkg::TIME_W-1:0] clip_time(input longint v);
      clip_time = (v > longint'(psm_pkg::TIME_MAX)) ? psm_pkg::TIME_MAX :
                  v[psm_pkg::TIME_W-1:0];
   endfunction

   task automatic schedule_list();
      psm_pkg::rec_type tmp;
      psm_pkg::rsp_type row;
      int sel;
      longint elapsed, tot_w, tot_t, wt, tt;
      elapsed = 0;
      tot_w = 0;
      tot_t = 0;
      for (int i = 0; i < held_count; i++) begin
         sel = i;
         for (int j = i + 1; j < held_count; j++) begin
            if (job_list[j].prio < job_list[sel].prio) sel = j;
         end
         tmp = job_list[i];
         job_list[i] = job_list[sel];
         job_list[sel] = tmp;
      end
      for (int i = 0; i < held_count; i++) begin
         wt = elapsed;
         tt = wt + job_list[i].burst;
         row = '0;
         row.row_kind = psm_pkg::ROW_PROCESS;
         row.process_number = job_list[i].num;
         row.burst_out = job_list[i].burst;
         row.waiting_time = clip_time(wt);
         row.turnaround_time = clip_time(tt);
         row_queue.push_back(row);
         tot_w += wt;
         tot_t += tt;
         elapsed = tt;
      end
      row = '0;
      row.row_kind = psm_pkg::ROW_SUMMARY;
      row.last_result = 1'b1;
      if (held_count > 0) begin
         row.avg_waiting = clip_time(tot_w / held_count);
         row.avg_turnaround = clip_time(tot_t / held_count);
      end
      row_queue.push_back(row);
      held_count = 0;
   endtask

   always @(posedge clock) begin
      psm_pkg::rsp_type want;
      if (reset) begin
         held_count = 0;
         row_queue.delete();
         fail_count = 0;
         lists_done = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (row_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected row %p", rsp_data);
            end else begin
               want = row_queue.pop_front();
               if (rsp_data !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("row mismatch: expected %p, got %p", want, rsp_data);
               end
               if (want.row_kind == psm_pkg::ROW_SUMMARY) lists_done++;
            end
         end
         if (req_valid && req_ready) begin
            if (held_count < MAX_PROCS) begin
               job_list[held_count].burst = req_data.burst_time;
               job_list[held_count].prio = req_data.priority_req;
               job_list[held_count].num = psm_pkg::PNUM_W'(held_count + 1);
               held_count++;
            end
            if (req_data.last_process) schedule_list();
         end
      end
      rows_pending = row_queue.size();
   end
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   psm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   psm_pkg::rsp_type rsp_data;
   int fail_count, rows_pending, lists_done;
   int cycle_count = 0;
   int hold_off = 0;
   bit random_stall = 1'b0;

   priority_schedule_metrics i_dut (.*);
   psm_checker i_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 2000000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver: a long hold-off when asked, otherwise random stalls when enabled, else always ready.
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off--;
         rsp_ready <= 1'b0;
      end else if (random_stall) begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Valid stays high after the transaction so that items can follow back to back;
   // a pause or a drain lowers it.
   task automatic send_process(input logic [15:0] burst, input logic [7:0] prio,
                               input logic last);
      req_valid <= 1'b1;
      req_data <= '{burst_time: burst, priority_req: prio, last_process: last};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic pause_cycles(input int n);
      if (n > 0) req_valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (rows_pending != 0) @(negedge clock);
   endtask

   task automatic send_random_list(input int len, input bit full_range);
      int gap;
      for (int k = 0; k < len; k++) begin
         gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
         pause_cycles(gap);
         send_process(full_range ? 16'($urandom) : 16'($urandom_range(0, 40)),
                      full_range ? 8'($urandom) : 8'($urandom_range(0, 3)),
                      k == len - 1);
      end
   endtask

   initial begin
      int sent;
      int len;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: single process, maximal values, ties and a full list.
      send_process(16'hFFFF, 8'hFF, 1'b1);
      send_process(16'h0000, 8'h00, 1'b1);
      send_process(16'd5, 8'd7, 1'b0);
      send_process(16'd3, 8'd7, 1'b0);
      send_process(16'd9, 8'd2, 1'b0);
      send_process(16'd1, 8'd7, 1'b1);
      wait_drain();
      // Overfull list: the extra process is dropped, its closing flag still counts.
      for (int k = 0; k < 33; k++) send_process(16'hFFFF, 8'(32 - k), k == 32);
      wait_drain();
      send_process(16'hAAAA, 8'h55, 1'b0);
      send_process(16'h5555, 8'hAA, 1'b1);

      random_stall = 1'b1;
      sent = 41;
      // Long receiver hold-off while the sender keeps offering.
      hold_off = 3000;
      send_random_list(20, 1'b1);
      send_random_list(6, 1'b0);
      sent += 26;
      wait_drain();
      while (sent < 220) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 8);
         send_random_list(len, $urandom_range(0, 1));
         sent += len;
         if ($urandom_range(0, 4) == 0) random_stall = !random_stall;
      end
      wait_drain();
      pause_cycles(2000);
      $display("Covered %0d processes in %0d job lists, ties, overfull lists and stalls.",
               sent, lists_done);
      if (fail_count == 0 && rows_pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
